// ===== design/assert_macros.svh =====
// Assertion macros for the upsampler RTL, used by upsmp_dp.
// Standalone header; the assertion forms are compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define UPS_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("upsampler assertion failed");
`define UPS_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("upsampler assertion failed");
`else
`define UPS_ASSERT(name, clk, rst_n, prop)
`define UPS_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// ===== design/upsmp_pkg.sv =====
// Package for the feature map upsampler: sizes, register indexes and the
// command and status types between controller and datapath. No dependencies.
package upsmp_pkg;

    localparam int DATA_WIDTH   = 32;
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int MAX_SCALE    = 8;
    localparam int MAX_CHANNELS = 4096;

    localparam int VAL_W   = 32;
    localparam int CH_W    = 12;
    localparam int POS_W   = 13;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 10;
    localparam int WID_W   = 11;
    localparam int HGT_W   = 11;
    localparam int CHC_W   = 13;
    localparam int SCL_W   = 4;
    localparam int OFS_W   = 3;
    localparam int IDX_W   = 3;
    localparam int CDATA_W = 13;

    localparam logic [VAL_W-1:0] VALUE_MASK =
        (DATA_WIDTH >= VAL_W) ? {VAL_W{1'b1}} : VAL_W'((64'd1 << DATA_WIDTH) - 64'd1);

    localparam logic [IDX_W-1:0] REG_IN_WIDTH      = 3'd0;
    localparam logic [IDX_W-1:0] REG_IN_HEIGHT     = 3'd1;
    localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [IDX_W-1:0] REG_SCALE         = 3'd3;
    localparam logic [IDX_W-1:0] REG_MODE          = 3'd4;

    typedef struct packed {
        logic load_item;
        logic emit;
    } upsmp_cmd_t;

    typedef struct packed {
        logic blk_end;
        logic out_free;
    } upsmp_sts_t;

endpackage

// ===== design/upsmp_ctrl.sv =====
// Controller for the upsampler: takes an input item, then steps the
// datapath through its block of results. Depends on upsmp_pkg.
module upsmp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  upsmp_pkg::upsmp_sts_t sts,
    output upsmp_pkg::upsmp_cmd_t cmd
);
    import upsmp_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.load_item = 1'b0;
        cmd.emit      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.blk_end)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/upsmp_dp.sv =====
// Datapath for the upsampler: configuration registers, position counters,
// block offsets and the output register. Depends on upsmp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module upsmp_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [upsmp_pkg::IDX_W-1:0]    cfg_index,
    input  logic [upsmp_pkg::CDATA_W-1:0]  cfg_data,
    input  logic [upsmp_pkg::VAL_W-1:0]    value,
    input  logic                           out_ready,
    input  upsmp_pkg::upsmp_cmd_t          cmd,
    output upsmp_pkg::upsmp_sts_t          sts,
    output logic                           out_valid,
    output logic [upsmp_pkg::VAL_W-1:0]    out_value,
    output logic [upsmp_pkg::CH_W-1:0]     channel,
    output logic [upsmp_pkg::POS_W-1:0]    out_row,
    output logic [upsmp_pkg::POS_W-1:0]    out_col,
    output logic                           last,
    output logic                           map_done
);
    import upsmp_pkg::*;

    logic [WID_W-1:0] in_width_reg;
    logic [HGT_W-1:0] in_height_reg;
    logic [CHC_W-1:0] channel_count_reg;
    logic [SCL_W-1:0] scale_reg;
    logic             mode_reg;

    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic [CH_W-1:0]  chan_count_reg, chan_count_next;

    logic [VAL_W-1:0] value_reg;
    logic [CH_W-1:0]  chan_item_reg;
    logic [POS_W-1:0] row_base_reg;
    logic [POS_W-1:0] col_base_reg;
    logic             final_reg;
    logic [OFS_W-1:0] dx_reg, dx_next;
    logic [OFS_W-1:0] dy_reg, dy_next;

    logic             out_valid_reg;
    logic [VAL_W-1:0] out_value_reg;
    logic [CH_W-1:0]  channel_reg;
    logic [POS_W-1:0] out_row_reg;
    logic [POS_W-1:0] out_col_reg;
    logic             last_reg;
    logic             map_done_reg;

    logic [WID_W-1:0] w_eff;
    logic [HGT_W-1:0] h_eff;
    logic [CHC_W-1:0] c_eff;
    logic [SCL_W-1:0] s_eff;
    logic [SCL_W-1:0] s_m1;
    logic             col_end, row_end, chan_end;
    logic             dx_end, dy_end;

    always_comb
    begin
        w_eff = (in_width_reg == '0) ? WID_W'(1) :
                (in_width_reg > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : in_width_reg;
        h_eff = (in_height_reg == '0) ? HGT_W'(1) :
                (in_height_reg > HGT_W'(MAX_HEIGHT)) ? HGT_W'(MAX_HEIGHT) : in_height_reg;
        c_eff = (channel_count_reg == '0) ? CHC_W'(1) :
                (channel_count_reg > CHC_W'(MAX_CHANNELS)) ? CHC_W'(MAX_CHANNELS)
                                                            : channel_count_reg;
        s_eff = (scale_reg == '0) ? SCL_W'(1) :
                (scale_reg > SCL_W'(MAX_SCALE)) ? SCL_W'(MAX_SCALE) : scale_reg;
        s_m1  = s_eff - SCL_W'(1);

        col_end  = (WID_W'(col_count_reg) + WID_W'(1)) >= w_eff;
        row_end  = (HGT_W'(row_count_reg) + HGT_W'(1)) >= h_eff;
        chan_end = (CHC_W'(chan_count_reg) + CHC_W'(1)) >= c_eff;

        col_count_next  = col_count_reg;
        row_count_next  = row_count_reg;
        chan_count_next = chan_count_reg;
        if (!col_end)
        begin
            col_count_next = col_count_reg + COL_W'(1);
        end
        else
        begin
            col_count_next = '0;
            if (!row_end)
            begin
                row_count_next = row_count_reg + ROW_W'(1);
            end
            else
            begin
                row_count_next = '0;
                if (!chan_end)
                begin
                    chan_count_next = chan_count_reg + CH_W'(1);
                end
                else
                begin
                    chan_count_next = '0;
                end
            end
        end

        dx_end = (SCL_W'(dx_reg) == s_m1);
        dy_end = (SCL_W'(dy_reg) == s_m1);
        dx_next = dx_reg + OFS_W'(1);
        dy_next = dy_reg;
        if (dx_end)
        begin
            dx_next = '0;
            dy_next = dy_end ? '0 : dy_reg + OFS_W'(1);
        end

        sts.blk_end  = dx_end && dy_end;
        sts.out_free = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg      <= WID_W'(1);
            in_height_reg     <= HGT_W'(1);
            channel_count_reg <= CHC_W'(1);
            scale_reg         <= SCL_W'(2);
            mode_reg          <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_IN_WIDTH:      in_width_reg      <= cfg_data[WID_W-1:0];
                REG_IN_HEIGHT:     in_height_reg     <= cfg_data[HGT_W-1:0];
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CHC_W-1:0];
                REG_SCALE:         scale_reg         <= cfg_data[SCL_W-1:0];
                REG_MODE:          mode_reg          <= cfg_data[0];
                default:           mode_reg          <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg  <= '0;
            row_count_reg  <= '0;
            chan_count_reg <= '0;
            dx_reg         <= '0;
            dy_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                col_count_reg  <= col_count_next;
                row_count_reg  <= row_count_next;
                chan_count_reg <= chan_count_next;
                dx_reg         <= '0;
                dy_reg         <= '0;
            end
            else if (cmd.emit)
            begin
                dx_reg <= dx_next;
                dy_reg <= dy_next;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            value_reg     <= value & VALUE_MASK;
            chan_item_reg <= chan_count_reg;
            row_base_reg  <= POS_W'(row_count_reg * s_eff);
            col_base_reg  <= POS_W'(col_count_reg * s_eff);
            final_reg     <= col_end && row_end && chan_end;
        end
        if (cmd.emit)
        begin
            out_value_reg <= (mode_reg || (dx_reg == '0 && dy_reg == '0)) ? value_reg : '0;
            channel_reg   <= chan_item_reg;
            out_row_reg   <= row_base_reg + POS_W'(dy_reg);
            out_col_reg   <= col_base_reg + POS_W'(dx_reg);
            last_reg      <= dx_end && dy_end;
            map_done_reg  <= dx_end && dy_end && final_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign channel   = channel_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign last      = last_reg;
    assign map_done  = map_done_reg;

    `UPS_ASSERT(a_done_has_last, clk, rst_n, (out_valid_reg && map_done_reg) |-> last_reg)
    `UPS_ASSERT(a_dx_in_block, clk, rst_n, SCL_W'(dx_reg) < s_eff)
    `UPS_ASSERT(a_dy_in_block, clk, rst_n, SCL_W'(dy_reg) < s_eff)

endmodule

// ===== design/feature_map_upsampler_top.sv =====
// The first result of an item comes from the output register, which is loaded from the item
// registers that capture its input transfer. Results leave the one output register at one
// result per cycle while out_ready does not stall it, after the state that takes the item.
// The next item is taken while the final result of the previous one still waits.
// Reset (rst_n, asynchronous, active low) restores the register defaults and
// clears the position counters; the configuration port is always ready.
module feature_map_upsampler_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [upsmp_pkg::IDX_W-1:0]   cfg_index,
    input  logic [upsmp_pkg::CDATA_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [upsmp_pkg::VAL_W-1:0]   value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [upsmp_pkg::VAL_W-1:0]   out_value,
    output logic [upsmp_pkg::CH_W-1:0]    channel,
    output logic [upsmp_pkg::POS_W-1:0]   out_row,
    output logic [upsmp_pkg::POS_W-1:0]   out_col,
    output logic                          last,
    output logic                          map_done
);
    import upsmp_pkg::*;

    upsmp_cmd_t cmd;
    upsmp_sts_t sts;

    assign cfg_ready = 1'b1;

    upsmp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    upsmp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .value     (value),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_value (out_value),
        .channel   (channel),
        .out_row   (out_row),
        .out_col   (out_col),
        .last      (last),
        .map_done  (map_done)
    );

endmodule

// ===== verif/feature_map_upsampler_top_tb.sv =====
// Self-checking testbench for feature_map_upsampler_top: predicts every output pixel per input
// element and compares transfers field by field under random idling on both channels.
// Depends on upsmp_pkg and the feature_map_upsampler_top RTL only.
module feature_map_upsampler_top_tb;
    import upsmp_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 16;

    typedef struct packed {
        logic [VAL_W-1:0] pix_value;
        logic [CH_W-1:0]  pix_chan;
        logic [POS_W-1:0] pix_row;
        logic [POS_W-1:0] pix_col;
        logic             pix_last;
        logic             pix_done;
    } pixel_t;

    class upsample_scoreboard;
        logic [WID_W-1:0] width_reg;
        logic [HGT_W-1:0] height_reg;
        logic [CHC_W-1:0] chans_reg;
        logic [SCL_W-1:0] scale_reg;
        logic             mode_reg;
        logic [COL_W-1:0] col_pos;
        logic [ROW_W-1:0] row_pos;
        logic [CH_W-1:0]  chan_pos;
        pixel_t           expected_pixels[$];
        int               errors;
        int               elements;
        int               pixels;
        int               maps;

        function new();
            width_reg  = 1;
            height_reg = 1;
            chans_reg  = 1;
            scale_reg  = 2;
            mode_reg   = 1'b1;
            col_pos    = '0;
            row_pos    = '0;
            chan_pos   = '0;
            errors     = 0;
            elements   = 0;
            pixels     = 0;
            maps       = 0;
        endfunction

        function int unsigned bound(int unsigned raw, int unsigned top);
            if (raw == 0)
            begin
                return 1;
            end
            return (raw > top) ? top : raw;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CDATA_W-1:0] data);
            case (idx)
                REG_IN_WIDTH:      width_reg  = data[WID_W-1:0];
                REG_IN_HEIGHT:     height_reg = data[HGT_W-1:0];
                REG_CHANNEL_COUNT: chans_reg  = data[CHC_W-1:0];
                REG_SCALE:         scale_reg  = data[SCL_W-1:0];
                REG_MODE:          mode_reg   = data[0];
                default:           ;
            endcase
        endfunction

        function void take_element(logic [VAL_W-1:0] raw);
            int unsigned      w;
            int unsigned      h;
            int unsigned      c;
            int unsigned      s;
            logic [VAL_W-1:0] v;
            bit               col_end;
            bit               row_end;
            bit               chan_end;
            pixel_t           p;
            w = bound(32'(width_reg), MAX_WIDTH);
            h = bound(32'(height_reg), MAX_HEIGHT);
            c = bound(32'(chans_reg), MAX_CHANNELS);
            s = bound(32'(scale_reg), MAX_SCALE);
            v = raw & VALUE_MASK;
            col_end  = (col_pos + 1) >= w;
            row_end  = (row_pos + 1) >= h;
            chan_end = (chan_pos + 1) >= c;
            for (int unsigned dy = 0; dy < s; dy++)
            begin
                for (int unsigned dx = 0; dx < s; dx++)
                begin
                    p.pix_value = (mode_reg || (dy == 0 && dx == 0)) ? v : '0;
                    p.pix_chan  = chan_pos;
                    p.pix_row   = POS_W'(row_pos * s + dy);
                    p.pix_col   = POS_W'(col_pos * s + dx);
                    p.pix_last  = (dy == s - 1) && (dx == s - 1);
                    p.pix_done  = p.pix_last && col_end && row_end && chan_end;
                    expected_pixels.push_back(p);
                end
            end
            elements++;
            if (!col_end)
            begin
                col_pos = col_pos + 1'b1;
            end
            else
            begin
                col_pos = '0;
                if (!row_end)
                begin
                    row_pos = row_pos + 1'b1;
                end
                else
                begin
                    row_pos = '0;
                    if (!chan_end)
                    begin
                        chan_pos = chan_pos + 1'b1;
                    end
                    else
                    begin
                        chan_pos = '0;
                        maps++;
                    end
                end
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void field_check(string field, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            end
        endfunction

        function void match_pixel(pixel_t got);
            pixel_t want;
            if (expected_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pixel, expected none, actual value %0h ch %0d",
                         $time, got.pix_value, got.pix_chan);
                $display("%0t: unexpected pixel at row %0d col %0d",
                         $time, got.pix_row, got.pix_col);
                return;
            end
            want = expected_pixels.pop_front();
            pixels++;
            field_check("out_value", want.pix_value, got.pix_value);
            field_check("channel", VAL_W'(want.pix_chan), VAL_W'(got.pix_chan));
            field_check("out_row", VAL_W'(want.pix_row), VAL_W'(got.pix_row));
            field_check("out_col", VAL_W'(want.pix_col), VAL_W'(got.pix_col));
            field_check("last", VAL_W'(want.pix_last), VAL_W'(got.pix_last));
            field_check("map_done", VAL_W'(want.pix_done), VAL_W'(got.pix_done));
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index;
    logic [CDATA_W-1:0]  cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic [VAL_W-1:0]    value;
    logic                out_valid;
    logic                out_ready;
    logic [VAL_W-1:0]    out_value;
    logic [CH_W-1:0]     channel;
    logic [POS_W-1:0]    out_row;
    logic [POS_W-1:0]    out_col;
    logic                last;
    logic                map_done;

    upsample_scoreboard book;
    bit                 calm;
    int                 n_writes;

    feature_map_upsampler_top u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            book.match_pixel(pixel_t'{out_value, channel, out_row, out_col, last, map_done});
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready) ||
                           (cfg_valid && cfg_ready)))
            begin
                quiet++;
            end
            else
            begin
                quiet = 0;
            end
        end
        $display("feature_map_upsampler_top_tb: done, errors");
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_item(input logic [VAL_W-1:0] v);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        value    <= v;
        do @(posedge clk); while (!in_ready);
        book.take_element(v);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (book.pending() != 0) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        book.write_reg(idx, data);
        n_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_shape(input logic [CDATA_W-1:0] w, h, c, s, m);
        cfg_write(REG_IN_WIDTH, w);
        cfg_write(REG_IN_HEIGHT, h);
        cfg_write(REG_CHANNEL_COUNT, c);
        cfg_write(REG_SCALE, s);
        cfg_write(REG_MODE, m);
    endtask

    task automatic random_setup();
        logic [WID_W-1:0] w;
        logic [HGT_W-1:0] h;
        logic [CHC_W-1:0] c;
        logic [SCL_W-1:0] s;
        w = ($urandom_range(0, 9) == 0) ? WID_W'($urandom) : WID_W'($urandom_range(0, 4));
        h = ($urandom_range(0, 9) == 0) ? HGT_W'($urandom) : HGT_W'($urandom_range(0, 3));
        c = ($urandom_range(0, 9) == 0) ? CHC_W'($urandom) : CHC_W'($urandom_range(0, 3));
        s = ($urandom_range(0, 4) == 0) ? SCL_W'($urandom) : SCL_W'($urandom_range(1, 3));
        set_shape({2'($urandom), w}, {2'($urandom), h}, c, {9'($urandom), s},
                  {12'($urandom), 1'($urandom)});
        if ($urandom_range(0, 3) == 0)
        begin
            cfg_write(IDX_W'($urandom_range(int'(REG_MODE) + 1, 2**IDX_W - 1)),
                      CDATA_W'($urandom));
        end
    endtask

    initial
    begin
        book      = new();
        calm      = 1'b0;
        n_writes  = 0;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        value     = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Register defaults after reset: every element closes a one-element map.
        push_item('0);
        push_item('1);
        settle();
        // Zero dimensions and zero scale act as one, zero-insert mode.
        set_shape('0, '0, '0, '0, '0);
        push_item(32'hA5A5_A5A5);
        push_item(32'h5A5A_5A5A);
        settle();
        // Scale above the maximum saturates; a full two-channel map.
        set_shape(2, 2, 2, 15, 0);
        repeat (8) push_item(rand_value());
        settle();
        // Shrinking the width mid-map wraps a counter that is past the new bound.
        set_shape(3, 1, 1, 1, 1);
        push_item(rand_value());
        push_item(rand_value());
        settle();
        cfg_write(REG_IN_WIDTH, 2);
        push_item(rand_value());
        push_item(rand_value());
        settle();
        for (int i = int'(REG_MODE) + 1; i < 2**IDX_W; i++)
        begin
            cfg_write(IDX_W'(i), '1);
        end
        push_item(rand_value());
        push_item(rand_value());
        settle();

        repeat (8)
        begin
            settle();
            random_setup();
            repeat ($urandom_range(30, 40)) push_item(rand_value());
        end
        settle();
        random_setup();
        calm = 1'b1;
        repeat (40) push_item(rand_value());

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Summary: %0d elements, %0d output pixels checked, %0d maps completed,",
                 book.elements, book.pixels, book.maps);
        $display("Summary: %0d register writes; both modes, scales 0 to 15, zero and oversized %s",
                 n_writes, "sizes, mid-map changes.");
        if (book.errors == 0)
        begin
            $display("feature_map_upsampler_top_tb: done, clean");
        end
        else
        begin
            $display("feature_map_upsampler_top_tb: done, errors");
        end
        $finish;
    end

endmodule
